FILE: sv/gtw_pkg.sv
// Shared types, constants and helpers for the tag pseudo-register walker.
package gtw_pkg;

	// Default packet length bound used for the payload fit test
	localparam int unsigned MAX_PACKET_QWORDS_DEF = 65536;

	// Tag field positions inside the low word
	localparam int unsigned FLG_LSB  = 58;
	localparam int unsigned NREG_LSB = 60;

	// Descriptor code for address-plus-data
	localparam logic [3:0] DESC_AD = 4'hE;

	// Tag format codes
	localparam logic [1:0] FLG_PACKED  = 2'd0;
	localparam logic [1:0] FLG_REGLIST = 2'd1;

	// Display pseudo register addresses
	localparam logic [7:0] ADDR_PMODE    = 8'h41;
	localparam logic [7:0] ADDR_SMODE2   = 8'h42;
	localparam logic [7:0] ADDR_DISPFB1  = 8'h59;
	localparam logic [7:0] ADDR_DISPLAY1 = 8'h5a;
	localparam logic [7:0] ADDR_DISPFB2  = 8'h5b;
	localparam logic [7:0] ADDR_DISPLAY2 = 8'h5c;
	localparam logic [7:0] ADDR_BGCOLOR  = 8'h5f;

	// Target register codes
	localparam logic [2:0] REG_PMODE    = 3'd0;
	localparam logic [2:0] REG_SMODE2   = 3'd1;
	localparam logic [2:0] REG_DISPFB1  = 3'd2;
	localparam logic [2:0] REG_DISPLAY1 = 3'd3;
	localparam logic [2:0] REG_DISPFB2  = 3'd4;
	localparam logic [2:0] REG_DISPLAY2 = 3'd5;
	localparam logic [2:0] REG_BGCOLOR  = 3'd6;

	// Register count that a zero NREG field stands for
	localparam logic [4:0] NREG_FULL = 5'd16;

	typedef enum logic [1:0] {
		MODE_TAG   = 2'd0,
		MODE_APPLY = 2'd1,
		MODE_SKIP  = 2'd2
	} walk_mode_t;

	// Outcome of decoding one tag quadword
	typedef struct packed {
		walk_mode_t  mode;
		logic        load_apply;
		logic        load_skip;
		logic [14:0] nloop;
		logic [4:0]  nreg;
		logic [19:0] skip;
	} tag_dec_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] code;
	} pseudo_t;

	// Map an address byte onto a pseudo register code
	function automatic pseudo_t pseudo_lookup(input logic [7:0] addr);
		pseudo_t r;
		r.hit = 1'b1;
		r.code = REG_PMODE;
		case (addr)
			ADDR_PMODE:    r.code = REG_PMODE;
			ADDR_SMODE2:   r.code = REG_SMODE2;
			ADDR_DISPFB1:  r.code = REG_DISPFB1;
			ADDR_DISPLAY1: r.code = REG_DISPLAY1;
			ADDR_DISPFB2:  r.code = REG_DISPFB2;
			ADDR_DISPLAY2: r.code = REG_DISPLAY2;
			ADDR_BGCOLOR:  r.code = REG_BGCOLOR;
			default:       r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/gtw_ifs.sv
// Channel interfaces: quadword input and pseudo register write output.
interface gtw_qword_if;
	logic        valid;
	logic        ready;
	logic [63:0] low_word;
	logic [63:0] high_word;
	logic [15:0] remaining_after;

	modport source(output valid, output low_word, output high_word,
		output remaining_after, input ready);
	modport sink(input valid, input low_word, input high_word,
		input remaining_after, output ready);
endinterface

interface gtw_write_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target_register;
	logic [63:0] write_value;

	modport source(output valid, output target_register, output write_value,
		input ready);
	modport sink(input valid, input target_register, input write_value,
		output ready);
endinterface

FILE: sv/gif_tag_pseudo_register_walker.sv
// Top level: input register, walker, and result register for pseudo register writes.
//
// Takes one 128-bit packet quadword per cycle, unless the output stalls, and
// walks its tags, emitting a write (target code 0..6 plus 64-bit value) for
// each address-plus-data payload quadword of a fitting PACKED tag that
// addresses a display pseudo register. Throughput is one quadword per clock
// while the output is not stalled. A taken quadword is decoded out of the
// input register, and its write is loaded into the result register when that
// register can take it. The rate is set by the walk state register, which
// decodes a tag or advances the loop/skip count for every quadword. A stalled
// output holds the pipeline only once the result register is occupied; the
// quadword that ends a packet returns the walk to its reset state.
module gif_tag_pseudo_register_walker #(
	parameter int unsigned MAX_PACKET_QWORDS = gtw_pkg::MAX_PACKET_QWORDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtw_qword_if.sink  qword,
	gtw_write_if.source pseudo_write
);

	logic        valid_s1;
	logic [63:0] low_s1;
	logic [63:0] high_s1;
	logic [15:0] rem_s1;

	logic        out_valid_q;
	logic [2:0]  target_q;
	logic [63:0] value_q;

	logic        advance;
	logic        hit;
	logic [2:0]  target;

	// Move the staged quadword on when the result register can take it
	assign advance     = valid_s1 && (!out_valid_q || pseudo_write.ready);
	assign qword.ready = !valid_s1 || advance;

	// Hold the accepted quadword
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (qword.ready) begin
			valid_s1 <= qword.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (qword.ready && qword.valid) begin
			low_s1  <= qword.low_word;
			high_s1 <= qword.high_word;
			rem_s1  <= qword.remaining_after;
		end
	end

	gtw_walker #(
		.MAX_PACKET_QWORDS(MAX_PACKET_QWORDS)
	) u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.low_word(low_s1),
		.high_word(high_s1),
		.remaining_after(rem_s1),
		.hit(hit),
		.target_register(target)
	);

	// Load or drain the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= hit;
		end else if (pseudo_write.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			target_q <= target;
			value_q  <= low_s1;
		end
	end

	assign pseudo_write.valid           = out_valid_q;
	assign pseudo_write.target_register = target_q;
	assign pseudo_write.write_value     = value_q;

endmodule

FILE: sv/gtw_tag_decode.sv
// Tag quadword decode: loop/register counts, fit test and skip length.
module gtw_tag_decode #(
	parameter int unsigned MAX_PACKET_QWORDS = gtw_pkg::MAX_PACKET_QWORDS_DEF
) (
	input  logic [63:0]      low_word,
	input  logic [63:0]      high_word,
	input  logic [15:0]      remaining_after,
	output gtw_pkg::tag_dec_t dec
);

	localparam logic [19:0] REM_LIMIT = 20'(MAX_PACKET_QWORDS - 1);

	logic [14:0] nloop;
	logic [1:0]  flg;
	logic [4:0]  nreg;
	logic [18:0] payload;
	logic [19:0] rem_eff;
	logic [19:0] skip_len;
	logic        has_ad;

	// Extract tag fields
	assign nloop = low_word[14:0];
	assign flg   = low_word[gtw_pkg::FLG_LSB +: 2];
	assign nreg  = (low_word[gtw_pkg::NREG_LSB +: 4] == 4'd0) ? gtw_pkg::NREG_FULL
		: {1'b0, low_word[gtw_pkg::NREG_LSB +: 4]};
	assign payload = 19'(nloop * nreg);

	// Clamp the remaining count to the packet bound
	assign rem_eff = ({4'd0, remaining_after} > REM_LIMIT) ? REM_LIMIT
		: {4'd0, remaining_after};

	// Look for an address-plus-data descriptor among the active slots
	always_comb begin
		has_ad = 1'b0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < nreg && high_word[4*i +: 4] == gtw_pkg::DESC_AD) begin
				has_ad = 1'b1;
			end
		end
	end

	// Pick the skip length for the tag format
	always_comb begin
		priority if (flg == gtw_pkg::FLG_PACKED) begin
			skip_len = {1'b0, payload};
		end else if (flg == gtw_pkg::FLG_REGLIST) begin
			skip_len = ({1'b0, payload} + 20'd1) >> 1;
		end else begin
			skip_len = {5'd0, nloop};
		end
	end

	// Choose the next walk mode
	always_comb begin
		dec.nloop      = nloop;
		dec.nreg       = nreg;
		dec.skip       = skip_len;
		dec.load_apply = 1'b0;
		dec.load_skip  = 1'b0;
		dec.mode       = gtw_pkg::MODE_TAG;
		if (nloop != 15'd0) begin
			if (flg == gtw_pkg::FLG_PACKED && has_ad && {1'b0, payload} <= rem_eff) begin
				dec.load_apply = 1'b1;
				dec.mode       = gtw_pkg::MODE_APPLY;
			end else if (skip_len != 20'd0) begin
				dec.load_skip = 1'b1;
				dec.mode      = gtw_pkg::MODE_SKIP;
			end
		end
	end

endmodule

FILE: sv/gtw_walker.sv
// Walk state: applies packed payload quadwords, counts skips, takes tags.
module gtw_walker #(
	parameter int unsigned MAX_PACKET_QWORDS = gtw_pkg::MAX_PACKET_QWORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [63:0] low_word,
	input  logic [63:0] high_word,
	input  logic [15:0] remaining_after,
	output logic        hit,
	output logic [2:0]  target_register
);

	gtw_pkg::walk_mode_t mode_q;
	logic [14:0]         loops_q;
	logic [3:0]          index_q;
	logic [4:0]          count_q;
	logic [63:0]         desc_q;
	logic [19:0]         skip_q;

	gtw_pkg::tag_dec_t dec;
	gtw_pkg::pseudo_t  pseudo;
	logic              applying;
	logic              skipping;
	logic [4:0]        slot_next;
	logic              wrap;
	logic [14:0]       loops_dec;
	logic [19:0]       skip_dec;

	gtw_tag_decode #(
		.MAX_PACKET_QWORDS(MAX_PACKET_QWORDS)
	) u_tag_decode (
		.low_word(low_word),
		.high_word(high_word),
		.remaining_after(remaining_after),
		.dec(dec)
	);

	assign applying = (mode_q == gtw_pkg::MODE_APPLY) && (loops_q != 15'd0);
	assign skipping = (mode_q == gtw_pkg::MODE_SKIP) && (skip_q != 20'd0);

	// Match the current descriptor slot against the address byte
	assign pseudo = gtw_pkg::pseudo_lookup(high_word[7:0]);
	assign hit = applying && (desc_q[4*index_q +: 4] == gtw_pkg::DESC_AD) && pseudo.hit;
	assign target_register = pseudo.code;

	assign slot_next = {1'b0, index_q} + 5'd1;
	assign wrap      = slot_next >= count_q;
	assign loops_dec = loops_q - 15'd1;
	assign skip_dec  = skip_q - 20'd1;

	// Advance the walk state once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= gtw_pkg::MODE_TAG;
			loops_q <= '0;
			index_q <= '0;
			count_q <= gtw_pkg::NREG_FULL;
			desc_q  <= '0;
			skip_q  <= '0;
		end else if (step) begin
			if (remaining_after == 16'd0) begin
				mode_q  <= gtw_pkg::MODE_TAG;
				loops_q <= '0;
				index_q <= '0;
				count_q <= gtw_pkg::NREG_FULL;
				desc_q  <= '0;
				skip_q  <= '0;
			end else if (applying) begin
				if (wrap) begin
					index_q <= '0;
					loops_q <= loops_dec;
					if (loops_dec == 15'd0) begin
						mode_q <= gtw_pkg::MODE_TAG;
					end
				end else begin
					index_q <= slot_next[3:0];
				end
			end else if (skipping) begin
				skip_q <= skip_dec;
				if (skip_dec == 20'd0) begin
					mode_q <= gtw_pkg::MODE_TAG;
				end
			end else begin
				mode_q <= dec.mode;
				if (dec.load_apply) begin
					loops_q <= dec.nloop;
					index_q <= '0;
					count_q <= dec.nreg;
					desc_q  <= high_word;
				end
				if (dec.load_skip) begin
					skip_q <= dec.skip;
				end
			end
		end
	end

endmodule
